>>> rtl/bta_pkg.sv
package bta_pkg;

	localparam int REQ_W    = 4;
	localparam int CFG_W    = 5;
	localparam int GIVEN_W  = 16;
	localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

	typedef enum logic {
		OP_TAKE    = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_DONE      = 3'd0,
		ST_EXHAUSTED = 3'd1,
		ST_HOLDS     = 3'd2,
		ST_NONE      = 3'd3,
		ST_BAD_INDEX = 3'd4
	} status_t;

	typedef struct packed {
		op_t               opcode;
		logic [REQ_W-1:0]  requester;
	} in_item_t;

	typedef struct packed {
		status_t             status;
		logic [GIVEN_W-1:0]  ticket_given;
		logic                grant_valid;
		logic [REQ_W-1:0]    grant_index;
	} out_item_t;

endpackage

>>> rtl/bta_min_tree.sv
module bta_min_tree #(
	parameter int N = 16,
	parameter int W = 16
) (
	input  logic [N-1:0][W-1:0]     vals,
	input  logic [N-1:0]            mask,
	output logic                    found,
	output logic [$clog2(N)-1:0]    index,
	output logic [W-1:0]            value
);

	localparam int IW     = $clog2(N);
	localparam int LEAVES = 1 << IW;
	localparam int NODES  = 2 * LEAVES - 1;

	// Heap layout: node k has children 2k+1 (lower indices) and 2k+2.
	logic [W-1:0]  node_v  [NODES];
	logic [IW-1:0] node_i  [NODES];
	logic          node_ok [NODES];

	genvar j, k;
	generate
		for (j = 0; j < LEAVES; j++) begin : g_leaf
			if (j < N) begin : g_used
				assign node_v[LEAVES-1+j]  = vals[j];
				assign node_i[LEAVES-1+j]  = IW'(j);
				assign node_ok[LEAVES-1+j] = mask[j];
			end else begin : g_pad
				assign node_v[LEAVES-1+j]  = '0;
				assign node_i[LEAVES-1+j]  = '0;
				assign node_ok[LEAVES-1+j] = 1'b0;
			end
		end
		for (k = 0; k < LEAVES - 1; k++) begin : g_node
			logic pick_l;
			// On equal values the left child wins, which keeps the lower index.
			assign pick_l = node_ok[2*k+1] &&
				(!node_ok[2*k+2] || (node_v[2*k+1] <= node_v[2*k+2]));
			assign node_v[k]  = pick_l ? node_v[2*k+1] : node_v[2*k+2];
			assign node_i[k]  = pick_l ? node_i[2*k+1] : node_i[2*k+2];
			assign node_ok[k] = node_ok[2*k+1] || node_ok[2*k+2];
		end
	endgenerate

	assign found = node_ok[0];
	assign index = node_i[0];
	assign value = node_v[0];

endmodule

>>> rtl/bta_core.sv
module bta_core #(
	parameter int MAX_REQUESTERS = 16,
	parameter int TICKET_BITS    = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  bta_pkg::in_item_t           item,
	input  logic [bta_pkg::CFG_W-1:0]   active_count,
	output bta_pkg::out_item_t          result
);

	localparam int IW   = $clog2(MAX_REQUESTERS);
	localparam int CW0  = $clog2(MAX_REQUESTERS + 1);
	localparam int CMPW = (CW0 > bta_pkg::CFG_W) ? CW0 : bta_pkg::CFG_W;
	localparam logic [CMPW-1:0]        MAX_C = CMPW'(MAX_REQUESTERS);
	localparam logic [TICKET_BITS-1:0] TICKET_TOP = '1;

	logic [MAX_REQUESTERS-1:0][TICKET_BITS-1:0] tickets_q;
	logic [MAX_REQUESTERS-1:0][TICKET_BITS-1:0] tickets_inv;
	logic [MAX_REQUESTERS-1:0] active_mask;
	logic [MAX_REQUESTERS-1:0] grant_mask;
	logic [CMPW-1:0]           active_ext;
	logic [CMPW-1:0]           live;
	logic [IW-1:0]             who;
	logic                      index_ok;
	logic [TICKET_BITS-1:0]    own;
	logic                      max_found;
	logic [IW-1:0]             max_index;
	logic [TICKET_BITS-1:0]    max_inv;
	logic [TICKET_BITS-1:0]    top;
	logic [TICKET_BITS-1:0]    given;
	logic                      drop_own;
	logic                      min_found;
	logic [IW-1:0]             min_index;
	logic [TICKET_BITS-1:0]    min_value;
	bta_pkg::status_t          status;

	assign active_ext = CMPW'(active_count);
	assign live       = (active_ext > MAX_C) ? MAX_C : active_ext;
	assign who        = IW'(item.requester);
	assign index_ok   = CMPW'(item.requester) < live;
	assign own        = tickets_q[who];

	genvar i;
	generate
		for (i = 0; i < MAX_REQUESTERS; i++) begin : g_mask
			assign active_mask[i] = CMPW'(i) < live;
			assign tickets_inv[i] = ~tickets_q[i];
			// A successful release takes its own ticket out of the grant search.
			assign grant_mask[i]  = active_mask[i] && (tickets_q[i] != '0) &&
				!(drop_own && (who == IW'(i)));
		end
	endgenerate

	// The largest ticket is the smallest of the inverted tickets.
	bta_min_tree #(.N(MAX_REQUESTERS), .W(TICKET_BITS)) u_max (
		.vals  (tickets_inv),
		.mask  (active_mask),
		.found (max_found),
		.index (max_index),
		.value (max_inv)
	);

	bta_min_tree #(.N(MAX_REQUESTERS), .W(TICKET_BITS)) u_grant (
		.vals  (tickets_q),
		.mask  (grant_mask),
		.found (min_found),
		.index (min_index),
		.value (min_value)
	);

	assign top   = max_found ? ~max_inv : '0;
	assign given = top + TICKET_BITS'(1);

	always_comb begin
		status   = bta_pkg::ST_DONE;
		drop_own = 1'b0;
		if (!index_ok) begin
			status = bta_pkg::ST_BAD_INDEX;
		end else if (item.opcode == bta_pkg::OP_TAKE) begin
			if (own != '0) begin
				status = bta_pkg::ST_HOLDS;
			end else if (top == TICKET_TOP) begin
				status = bta_pkg::ST_EXHAUSTED;
			end
		end else begin
			if (own == '0) begin
				status = bta_pkg::ST_NONE;
			end else begin
				drop_own = 1'b1;
			end
		end
	end

	// A new ticket is above every active ticket, so it wins only when no one
	// else holds one.
	always_comb begin
		result.status       = status;
		result.ticket_given = '0;
		result.grant_valid  = min_found;
		result.grant_index  = min_found ? bta_pkg::REQ_W'(min_index) : '0;
		if (status == bta_pkg::ST_DONE && item.opcode == bta_pkg::OP_TAKE) begin
			result.ticket_given = bta_pkg::GIVEN_W'(given);
			result.grant_valid  = 1'b1;
			if (!min_found) begin
				result.grant_index = item.requester;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tickets_q <= '0;
		end else if (fire && status == bta_pkg::ST_DONE) begin
			if (item.opcode == bta_pkg::OP_TAKE) begin
				tickets_q[who] <= given;
			end else begin
				tickets_q[who] <= '0;
			end
		end
	end

endmodule

>>> rtl/bakery_ticket_arbiter.sv
// Pipeline: a request is registered in the input stage, and its result in the result stage.
// Throughput: one request per cycle unless out_stall holds the result; the ticket file is read by a max tree and a
// min tree in the same cycle, and that pair of trees sets the clock.
// Reset: asynchronous, active low; all tickets clear to zero, the active count
// returns to sixteen, and both the input and result stages empty.
module bakery_ticket_arbiter #(
	parameter int MAX_REQUESTERS = 16,
	parameter int TICKET_BITS    = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  bta_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output bta_pkg::out_item_t          out_data,
	input  logic                        cfg_we,
	input  logic [bta_pkg::CFG_W-1:0]   cfg_data
);

	logic                        in_valid_s1;
	bta_pkg::in_item_t           in_item_s1;
	logic                        res_valid_s2;
	bta_pkg::out_item_t          res_item_s2;
	logic [bta_pkg::CFG_W-1:0]   active_count_q;
	logic                        advance;
	logic                        accept;
	bta_pkg::out_item_t          result;

	assign advance  = in_valid_s1 && (!res_valid_s2 || !out_stall);
	assign in_stall = in_valid_s1 && res_valid_s2 && out_stall;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_count_q <= bta_pkg::ACTIVE_RESET;
		end else if (cfg_we) begin
			active_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (accept) begin
			in_valid_s1 <= 1'b1;
		end else if (advance) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_item_s1 <= in_data;
		end
	end

	bta_core #(
		.MAX_REQUESTERS (MAX_REQUESTERS),
		.TICKET_BITS    (TICKET_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (advance),
		.item         (in_item_s1),
		.active_count (active_count_q),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_item_s2 <= result;
		end
	end

	assign out_valid = res_valid_s2;
	assign out_data  = res_item_s2;

endmodule

>>> rtl/bta_checker.sv
module bta_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input bta_pkg::in_item_t           in_data,
	input logic                        out_valid,
	input logic                        out_stall,
	input bta_pkg::out_item_t          out_data
);

	// A stalled request keeps its payload until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("request changed while stalled");

	// A result held back by the receiver stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Failed requests never hand out a ticket.
	a_err_no_ticket: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != bta_pkg::ST_DONE |-> out_data.ticket_given == '0)
		else $error("ticket given on a refused request");

	// A ticket just handed out means someone holds the grant.
	a_take_grants: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.ticket_given != '0 |-> out_data.grant_valid)
		else $error("ticket given but no grant");

	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.grant_valid |-> out_data.grant_index == '0)
		else $error("grant index set without a grant");

endmodule

bind bakery_ticket_arbiter bta_checker u_bta_checker (.*);
